FILE: src/hbs_pkg.sv
package hbs_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;
    localparam int GRID_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(GRID_DEPTH);
    localparam int DIM_W = 9;
    localparam int FRAC_W = 16;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_SAMPLE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         col;
        logic [7:0]         row;
        logic signed [15:0] height_in;
        logic [16:0]        u_coord;
        logic [16:0]        v_coord;
    } item_t;

    typedef struct packed {
        logic signed [31:0] height_out;
        logic               out_of_range;
    } result_t;

    typedef enum logic [1:0] {
        ADDR_00 = 2'd0,
        ADDR_10 = 2'd1,
        ADDR_01 = 2'd2,
        ADDR_11 = 2'd3
    } addr_sel_t;

    typedef enum logic [1:0] {
        RES_CELL      = 2'd0,
        RES_OUT_RANGE = 2'd1,
        RES_ZERO      = 2'd2,
        RES_LERP      = 2'd3
    } res_sel_t;

    typedef struct packed {
        logic      capture;
        logic      scale;
        logic      rows;
        logic      mem_rd;
        logic      mem_wr;
        addr_sel_t addr_sel;
        logic      cap_h00;
        logic      cap_h10;
        logic      cap_h01;
        logic      cap_h11;
        logic      lerp_a;
        logic      lerp_b;
        logic      load_res;
        res_sel_t  res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic grid_empty;
    } dp_status_t;

endpackage

FILE: src/hbs_datapath.sv
module hbs_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hbs_pkg::item_t            item,
    input  logic                      cfg_write,
    input  hbs_pkg::cfg_index_t       cfg_index,
    input  logic [hbs_pkg::DIM_W-1:0] cfg_data,
    input  hbs_pkg::dp_cmd_t          cmd,
    output hbs_pkg::dp_status_t       status,
    output hbs_pkg::result_t          result,
    output logic                      done
);
    import hbs_pkg::*;

    logic [DIM_W-1:0]  grid_width_reg;
    logic [DIM_W-1:0]  grid_height_reg;
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [7:0]        w_m1;
    logic [7:0]        h_m1;

    item_t             item_reg;
    logic [16:0]       u_sat;
    logic [16:0]       v_sat;
    logic [23:0]       fx_next;
    logic [23:0]       fz_next;
    logic [23:0]       fx_reg;
    logic [23:0]       fz_reg;

    logic [7:0]        x0;
    logic [7:0]        z0;
    logic [7:0]        x1;
    logic [7:0]        z1;
    logic [16:0]       row0_prod;
    logic [16:0]       row1_prod;
    logic [7:0]        x0_reg;
    logic [7:0]        x1_reg;
    logic [ADDR_W-1:0] row0_reg;
    logic [ADDR_W-1:0] row1_reg;
    logic [ADDR_W-1:0] addr;

    logic signed [15:0] grid_mem [GRID_DEPTH];
    logic signed [15:0] mem_q_reg;
    logic signed [15:0] h00_reg;
    logic signed [15:0] h10_reg;
    logic signed [15:0] h01_reg;
    logic signed [15:0] h11_reg;

    logic signed [32:0] mul_a;
    logic [15:0]        mul_frac;
    logic signed [49:0] base;
    logic signed [49:0] mul_a_ext;
    logic signed [49:0] mul_b_ext;
    logic signed [49:0] mult_res;
    logic signed [49:0] row_sum;
    logic signed [49:0] col_sum;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;

    result_t           result_next;
    result_t           result_reg;
    logic              done_reg;

    // grid size registers, oversized values act as the maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= '0;
            grid_height_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff = (grid_width_reg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_width_reg;
    assign h_eff = (grid_height_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_height_reg;
    assign w_m1 = 8'(w_eff - DIM_W'(1));
    assign h_m1 = 8'(h_eff - DIM_W'(1));

    assign status.in_range = ({1'b0, item.col} < w_eff) && ({1'b0, item.row} < h_eff);
    assign status.grid_empty = (w_eff == '0) || (h_eff == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
    end

    // scale the coordinates into cell units
    assign u_sat = (item_reg.u_coord > ONE_Q16) ? ONE_Q16 : item_reg.u_coord;
    assign v_sat = (item_reg.v_coord > ONE_Q16) ? ONE_Q16 : item_reg.v_coord;
    assign fx_next = 24'(u_sat) * 24'(w_m1);
    assign fz_next = 24'(v_sat) * 24'(h_m1);

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            fx_reg <= fx_next;
            fz_reg <= fz_next;
        end
    end

    // base cell and clamped neighbor, then row offsets
    assign x0 = (item_reg.kind == KIND_SAMPLE) ? fx_reg[23:16] : item_reg.col;
    assign z0 = (item_reg.kind == KIND_SAMPLE) ? fz_reg[23:16] : item_reg.row;
    assign x1 = ((DIM_W'(x0) + DIM_W'(1)) < w_eff) ? 8'(x0 + 8'd1) : w_m1;
    assign z1 = ((DIM_W'(z0) + DIM_W'(1)) < h_eff) ? 8'(z0 + 8'd1) : h_m1;
    assign row0_prod = 17'(z0) * 17'(w_eff);
    assign row1_prod = 17'(z1) * 17'(w_eff);

    always_ff @(posedge clk)
    begin
        if (cmd.rows)
        begin
            x0_reg   <= x0;
            x1_reg   <= x1;
            row0_reg <= row0_prod[ADDR_W-1:0];
            row1_reg <= row1_prod[ADDR_W-1:0];
        end
    end

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_00: addr = row0_reg + ADDR_W'(x0_reg);
            ADDR_10: addr = row0_reg + ADDR_W'(x1_reg);
            ADDR_01: addr = row1_reg + ADDR_W'(x0_reg);
            ADDR_11: addr = row1_reg + ADDR_W'(x1_reg);
            default: addr = row0_reg + ADDR_W'(x0_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            grid_mem[addr] <= item_reg.height_in;
        end
        if (cmd.mem_rd)
        begin
            mem_q_reg <= grid_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_h00)
        begin
            h00_reg <= mem_q_reg;
        end
        if (cmd.cap_h10)
        begin
            h10_reg <= mem_q_reg;
        end
        if (cmd.cap_h01)
        begin
            h01_reg <= mem_q_reg;
        end
        if (cmd.cap_h11)
        begin
            h11_reg <= mem_q_reg;
        end
    end

    // one shared multiplier: row lerp along u twice, then column lerp along v
    always_comb
    begin
        if (cmd.lerp_a)
        begin
            mul_a    = {{17{h10_reg[15]}}, h10_reg} - {{17{h00_reg[15]}}, h00_reg};
            mul_frac = fx_reg[15:0];
            base     = {{18{h00_reg[15]}}, h00_reg, 16'b0};
        end
        else if (cmd.lerp_b)
        begin
            mul_a    = {{17{h11_reg[15]}}, h11_reg} - {{17{h01_reg[15]}}, h01_reg};
            mul_frac = fx_reg[15:0];
            base     = {{18{h01_reg[15]}}, h01_reg, 16'b0};
        end
        else
        begin
            mul_a    = {b_reg[31], b_reg} - {a_reg[31], a_reg};
            mul_frac = fz_reg[15:0];
            base     = {{18{a_reg[31]}}, a_reg};
        end
    end

    assign mul_a_ext = {{17{mul_a[32]}}, mul_a};
    assign mul_b_ext = {34'b0, mul_frac};
    assign mult_res = mul_a_ext * mul_b_ext;
    assign row_sum = base + mult_res;
    // floor of the q32 sum back to q16
    assign col_sum = base + (mult_res >>> FRAC_W);

    always_ff @(posedge clk)
    begin
        if (cmd.lerp_a)
        begin
            a_reg <= row_sum[31:0];
        end
        if (cmd.lerp_b)
        begin
            b_reg <= row_sum[31:0];
        end
    end

    always_comb
    begin
        result_next.out_of_range = 1'b0;
        case (cmd.res_sel)
            RES_CELL:      result_next.height_out = {{16{mem_q_reg[15]}}, mem_q_reg};
            RES_OUT_RANGE:
            begin
                result_next.height_out   = '0;
                result_next.out_of_range = 1'b1;
            end
            RES_ZERO:      result_next.height_out = '0;
            RES_LERP:      result_next.height_out = col_sum[31:0];
            default:       result_next.height_out = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_res)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.load_res;
        end
    end

    assign result = result_reg;
    assign done = done_reg;

endmodule

FILE: src/hbs_ctrl.sv
module hbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  hbs_pkg::kind_t      kind,
    input  hbs_pkg::dp_status_t status,
    output logic                busy,
    output hbs_pkg::dp_cmd_t    cmd
);
    import hbs_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_SCALE  = 12'b0000_0000_0010,
        S_ROWS   = 12'b0000_0000_0100,
        S_WRITE  = 12'b0000_0000_1000,
        S_RD0    = 12'b0000_0001_0000,
        S_RDOUT  = 12'b0000_0010_0000,
        S_RD1    = 12'b0000_0100_0000,
        S_RD2    = 12'b0000_1000_0000,
        S_RD3    = 12'b0001_0000_0000,
        S_LERP_A = 12'b0010_0000_0000,
        S_LERP_B = 12'b0100_0000_0000,
        S_LERP_V = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    kind_t  kind_reg;
    kind_t  kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= KIND_NONE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    kind_next   = kind;
                    case (kind)
                        KIND_WRITE:
                        begin
                            if (status.in_range)
                            begin
                                state_next = S_ROWS;
                            end
                        end
                        KIND_READ:
                        begin
                            if (status.in_range)
                            begin
                                state_next = S_ROWS;
                            end
                            else
                            begin
                                cmd.load_res = 1'b1;
                                cmd.res_sel  = RES_OUT_RANGE;
                            end
                        end
                        KIND_SAMPLE:
                        begin
                            if (status.grid_empty)
                            begin
                                cmd.load_res = 1'b1;
                                cmd.res_sel  = RES_ZERO;
                            end
                            else
                            begin
                                state_next = S_SCALE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_ROWS;
            end
            S_ROWS:
            begin
                cmd.rows   = 1'b1;
                state_next = (kind_reg == KIND_WRITE) ? S_WRITE : S_RD0;
            end
            S_WRITE:
            begin
                cmd.mem_wr   = 1'b1;
                cmd.addr_sel = ADDR_00;
                state_next   = S_IDLE;
            end
            S_RD0:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_00;
                state_next   = (kind_reg == KIND_READ) ? S_RDOUT : S_RD1;
            end
            S_RDOUT:
            begin
                cmd.load_res = 1'b1;
                cmd.res_sel  = RES_CELL;
                state_next   = S_IDLE;
            end
            // each read lands in mem_q_reg in the cycle after its address
            S_RD1:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_10;
                cmd.cap_h00  = 1'b1;
                state_next   = S_RD2;
            end
            S_RD2:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_01;
                cmd.cap_h10  = 1'b1;
                state_next   = S_RD3;
            end
            S_RD3:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_11;
                cmd.cap_h01  = 1'b1;
                state_next   = S_LERP_A;
            end
            S_LERP_A:
            begin
                cmd.cap_h11 = 1'b1;
                cmd.lerp_a  = 1'b1;
                state_next  = S_LERP_B;
            end
            S_LERP_B:
            begin
                cmd.lerp_b = 1'b1;
                state_next = S_LERP_V;
            end
            S_LERP_V:
            begin
                cmd.load_res = 1'b1;
                cmd.res_sel  = RES_LERP;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/heightmap_bilinear_sampler_top.sv
// Heightmap bilinear sampler: a 256 x 256 grid of signed 16-bit heights in one
// single-ported memory, addressed row * width + col. An item is taken when start
// is high and busy is low. A write or read in range and a bilinear sample raise
// busy; a sample's four neighbor cells come one after another from the single
// memory port, and the two row lerps and the column lerp share one multiplier.
// Out-of-range reads, samples of an empty grid and unused kinds never raise
// busy; out-of-range writes are dropped. Each result beat shows on result for
// exactly one cycle with done high, in the cycle after the item's last state in
// the controller, and the receiver cannot stall it. The grid is not cleared by
// reset: a cell read before it has been written returns an undefined value.
// Grid size registers are written through cfg_write/cfg_index/cfg_data; the user
// must write them only while the block is idle; the block does not enforce it.
module heightmap_bilinear_sampler_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  hbs_pkg::item_t            item,
    output hbs_pkg::result_t          result,
    output logic                      done,
    input  logic                      cfg_write,
    input  hbs_pkg::cfg_index_t       cfg_index,
    input  logic [hbs_pkg::DIM_W-1:0] cfg_data
);
    import hbs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    hbs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (item.kind),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    hbs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .done      (done)
    );

endmodule

FILE: src/hbs_checker.sv
module hbs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input hbs_pkg::item_t   item,
    input hbs_pkg::result_t result,
    input logic             done
);
    import hbs_pkg::*;

    // a result beat always ends an item, so the block is idle when it shows
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
    else $error("result beat while busy");

    // a result beat follows an accepted item or a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
    else $error("result beat without work");

    // writes and unused kinds never give a beat on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.kind == KIND_WRITE || item.kind == KIND_NONE)) |=> !done)
    else $error("beat after write or unused kind");

    // out-of-range reads carry a zero height
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.out_of_range) |-> (result.height_out == '0))
    else $error("out-of-range beat with nonzero height");

endmodule

bind heightmap_bilinear_sampler_top hbs_checker u_hbs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .result (result),
    .done   (done)
);
